FILE: rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int PIX_W = 8;   // channel byte
  localparam int HUE_W = 15;  // hue field
  localparam int SAT_W = 16;  // saturation field
  localparam int DIV_W = 9;   // divisors are 2*max or 2*delta
  localparam int REM_W = 10;  // partial remainder after the shift-in

  localparam int IN_W  = 3 * PIX_W;
  localparam int RES_W = HUE_W + SAT_W + PIX_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Side data that travels along the divider cells with each pixel
  typedef struct packed {
    logic             gray;
    logic [PIX_W-1:0] value;
  } side_t;

endpackage

FILE: rtl/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter: front stage, divider cell row, output skid.
//
//  channel | dir | tdata fields (low bit up)                      | tuser/tlast
//  s_axis  | in  | red[7:0] green[15:8] blue[23:16]                | none
//  m_axis  | out | hue[14:0] saturation[30:15] value[38:31], 0     | none
//
// One pixel per clock while the output does not stall. The stages are one set-up
// register, one cell per quotient bit of the two row-shared restoring dividers
// (QW = max(SAT_BITS, HUE_FRAC_BITS + 9) quotient bits), and one output register.
// Synchronous reset clears the valid bits of every stage and the output.
// A stalled output parks one more result in the skid stage; s_tready then drops
// and the whole row holds until the skid stage drains.
module rgb_to_hsv_converter_core #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_BITS      = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rgbhsv_pkg::IN_W-1:0]  s_tdata,   // red, green, blue
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rgbhsv_pkg::OUT_W-1:0] m_tdata    // hue, saturation, value, pad
);
  import rgbhsv_pkg::*;

  localparam int QW = (SAT_BITS > HUE_FRAC_BITS + 9) ? SAT_BITS : HUE_FRAC_BITS + 9;
  localparam logic [QW-1:0] HUE_FULL = QW'(360 * (1 << HUE_FRAC_BITS));

  logic             ce;
  logic             vld      [QW+1];
  side_t            side     [QW+1];
  logic [REM_W-1:0] sat_rem  [QW+1];
  logic [QW-1:0]    sat_word [QW+1];
  logic [DIV_W-1:0] sat_div  [QW+1];
  logic [REM_W-1:0] hue_rem  [QW+1];
  logic [QW-1:0]    hue_word [QW+1];
  logic [DIV_W-1:0] hue_div  [QW+1];

  logic [HUE_W-1:0] hue_fin;
  logic [SAT_W-1:0] sat_fin;
  logic [RES_W-1:0] res_data, out_res;

  assign s_tready = ce;

  rgbhsv_front #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_BITS      (SAT_BITS),
    .QW            (QW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (s_tvalid),
    .red          (s_tdata[PIX_W-1:0]),
    .green        (s_tdata[2*PIX_W-1:PIX_W]),
    .blue         (s_tdata[3*PIX_W-1:2*PIX_W]),
    .out_valid    (vld[0]),
    .out_side     (side[0]),
    .out_sat_rem  (sat_rem[0]),
    .out_sat_word (sat_word[0]),
    .out_sat_div  (sat_div[0]),
    .out_hue_rem  (hue_rem[0]),
    .out_hue_word (hue_word[0]),
    .out_hue_div  (hue_div[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rgbhsv_cell #(
      .QW (QW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ce           (ce),
      .in_valid     (vld[i]),
      .in_side      (side[i]),
      .in_sat_rem   (sat_rem[i]),
      .in_sat_word  (sat_word[i]),
      .in_sat_div   (sat_div[i]),
      .in_hue_rem   (hue_rem[i]),
      .in_hue_word  (hue_word[i]),
      .in_hue_div   (hue_div[i]),
      .out_valid    (vld[i+1]),
      .out_side     (side[i+1]),
      .out_sat_rem  (sat_rem[i+1]),
      .out_sat_word (sat_word[i+1]),
      .out_sat_div  (sat_div[i+1]),
      .out_hue_rem  (hue_rem[i+1]),
      .out_hue_word (hue_word[i+1]),
      .out_hue_div  (hue_div[i+1])
    );
  end

  // gray pixels give zero hue and saturation; a hue rounded to a full turn wraps
  always_comb begin
    if (side[QW].gray || hue_word[QW] >= HUE_FULL) begin
      hue_fin = '0;
    end else begin
      hue_fin = HUE_W'(hue_word[QW]);
    end
    sat_fin  = side[QW].gray ? '0 : SAT_W'(sat_word[QW]);
    res_data = {side[QW].value, sat_fin, hue_fin};
  end

  rgbhsv_skid #(
    .W (RES_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[QW]),
    .in_ready  (ce),
    .in_data   (res_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = OUT_W'(out_res);

endmodule

FILE: rtl/rgbhsv_front.sv
// Front stage: max/min, sector, and dividend/divisor set-up for both dividers.
module rgbhsv_front #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_BITS      = 16,
  parameter int QW            = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic [rgbhsv_pkg::PIX_W-1:0] red,
  input  logic [rgbhsv_pkg::PIX_W-1:0] green,
  input  logic [rgbhsv_pkg::PIX_W-1:0] blue,
  output logic                        out_valid,
  output rgbhsv_pkg::side_t           out_side,
  output logic [rgbhsv_pkg::REM_W-1:0] out_sat_rem,
  output logic [QW-1:0]               out_sat_word,
  output logic [rgbhsv_pkg::DIV_W-1:0] out_sat_div,
  output logic [rgbhsv_pkg::REM_W-1:0] out_hue_rem,
  output logic [QW-1:0]               out_hue_word,
  output logic [rgbhsv_pkg::DIV_W-1:0] out_hue_div
);
  import rgbhsv_pkg::*;

  localparam int NS_W = SAT_BITS + 9;
  localparam int NH_W = HUE_FRAC_BITS + 18;

  logic [PIX_W-1:0]  mx, mn, delta;
  sector_t           sector;
  logic signed [8:0] num;
  logic signed [18:0] num_x, del_x, off_x, m_raw, m_wrap;
  logic [16:0]       m_u;
  logic [NS_W-1:0]   sat_num;
  logic [NH_W-1:0]   hue_num;

  always_comb begin
    // ties go to red, then green
    if (red >= green && red >= blue) begin
      sector = SEC_RED;
      mx     = red;
    end else if (green >= blue) begin
      sector = SEC_GREEN;
      mx     = green;
    end else begin
      sector = SEC_BLUE;
      mx     = blue;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    case (sector)
      SEC_RED: begin
        num   = $signed({1'b0, green}) - $signed({1'b0, blue});
        off_x = 19'sd0;
      end
      SEC_GREEN: begin
        num   = $signed({1'b0, blue}) - $signed({1'b0, red});
        off_x = 19'sd120;
      end
      SEC_BLUE: begin
        num   = $signed({1'b0, red}) - $signed({1'b0, green});
        off_x = 19'sd240;
      end
      default: begin
        num   = '0;
        off_x = 19'sd0;
      end
    endcase

    // hue in whole degrees times delta; wrap a negative red-sector hue
    num_x  = 19'(num);
    del_x  = $signed({11'd0, delta});
    m_raw  = num_x * 19'sd60 + del_x * off_x;
    m_wrap = (m_raw < 0) ? m_raw + del_x * 19'sd360 : m_raw;
    m_u    = m_wrap[16:0];

    hue_num = (NH_W'(m_u) << (HUE_FRAC_BITS + 1)) + NH_W'(delta);
    sat_num = (NS_W'(delta) << (SAT_BITS + 1)) - (NS_W'(delta) << 1) + NS_W'(mx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_side.gray  <= (delta == '0);
      out_side.value <= mx;
      out_sat_rem    <= REM_W'(sat_num >> QW);
      out_sat_word   <= QW'(sat_num);
      out_sat_div    <= {mx, 1'b0};
      out_hue_rem    <= REM_W'(hue_num >> QW);
      out_hue_word   <= QW'(hue_num);
      out_hue_div    <= {delta, 1'b0};
    end
  end

endmodule

FILE: rtl/rgbhsv_cell.sv
// Divider cell: one restoring quotient bit for the saturation and hue lanes.
module rgbhsv_cell #(
  parameter int QW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  rgbhsv_pkg::side_t           in_side,
  input  logic [rgbhsv_pkg::REM_W-1:0] in_sat_rem,
  input  logic [QW-1:0]               in_sat_word,
  input  logic [rgbhsv_pkg::DIV_W-1:0] in_sat_div,
  input  logic [rgbhsv_pkg::REM_W-1:0] in_hue_rem,
  input  logic [QW-1:0]               in_hue_word,
  input  logic [rgbhsv_pkg::DIV_W-1:0] in_hue_div,
  output logic                        out_valid,
  output rgbhsv_pkg::side_t           out_side,
  output logic [rgbhsv_pkg::REM_W-1:0] out_sat_rem,
  output logic [QW-1:0]               out_sat_word,
  output logic [rgbhsv_pkg::DIV_W-1:0] out_sat_div,
  output logic [rgbhsv_pkg::REM_W-1:0] out_hue_rem,
  output logic [QW-1:0]               out_hue_word,
  output logic [rgbhsv_pkg::DIV_W-1:0] out_hue_div
);
  import rgbhsv_pkg::*;

  logic [REM_W-1:0] sat_t, hue_t, sat_rem_next, hue_rem_next;
  logic             sat_q, hue_q;

  // shift the next dividend bit into the remainder; the quotient bit
  // takes its place at the bottom of the word
  always_comb begin
    sat_t        = {in_sat_rem[REM_W-2:0], in_sat_word[QW-1]};
    sat_q        = (sat_t >= REM_W'(in_sat_div));
    sat_rem_next = sat_q ? sat_t - REM_W'(in_sat_div) : sat_t;
    hue_t        = {in_hue_rem[REM_W-2:0], in_hue_word[QW-1]};
    hue_q        = (hue_t >= REM_W'(in_hue_div));
    hue_rem_next = hue_q ? hue_t - REM_W'(in_hue_div) : hue_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_side     <= in_side;
      out_sat_rem  <= sat_rem_next;
      out_sat_word <= {in_sat_word[QW-2:0], sat_q};
      out_sat_div  <= in_sat_div;
      out_hue_rem  <= hue_rem_next;
      out_hue_word <= {in_hue_word[QW-2:0], hue_q};
      out_hue_div  <= in_hue_div;
    end
  end

endmodule

FILE: rtl/rgbhsv_skid.sv
// Output register with a skid stage that takes one more result under a stall, so in_ready is registered.
module rgbhsv_skid #(
  parameter int W = 39
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_valid;
          out_data  <= in_data;
        end
      end else if (in_valid && !skid_valid) begin
        // park the transaction while the output is held
        skid_valid <= 1'b1;
        skid_data  <= in_data;
      end
    end
  end

endmodule

FILE: rtl/rgbhsv_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rgbhsv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rgbhsv_pkg::OUT_W-1:0] m_tdata
);
  import rgbhsv_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // input back-pressure only follows a stalled output transaction
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without an output stall");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result on offer");

  // a black pixel carries no hue or saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[RES_W-1:HUE_W+SAT_W] == '0 |->
      m_tdata[HUE_W+SAT_W-1:0] == '0)
    else $error("black pixel with hue or saturation");

  a_reset_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_checker u_rgbhsv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
